### hdl/soiir_pkg.sv
// shared types and constants for the sixth-order iir filter
// tap count, coefficient format, reset coefficients and the cell control bundle
// no dependencies
package soiir_pkg;

  localparam int NTAPS              = 6;
  localparam int COEF_W             = 16;
  localparam int CFG_IDX_W          = 3;
  localparam int SAMPLE_WIDTH_DEF   = 16;
  localparam int OUT_WIDTH_DEF      = 24;
  localparam int COEF_FRAC_BITS_DEF = 12;

  typedef logic signed [COEF_W-1:0] coef_t;

  // feedback coefficients a1..a6, q3.12
  localparam coef_t COEF_RESET [NTAPS] = '{
    16'sd12984, -16'sd18104, 16'sd14254, -16'sd6676, 16'sd1761, -16'sd205
  };

  typedef struct packed {
    logic  shift;
    logic  coef_we;
    coef_t coef_wdata;
  } cell_ctrl_t;

endpackage

### hdl/soiir_cell.sv
// one tap cell: holds x[n-1-k], y[n-1-k] and coefficient a(k+1)
// shifts history to its neighbor on each accepted beat; uses soiir_pkg
module soiir_cell
  import soiir_pkg::*;
#(
  parameter int    SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int    OUT_WIDTH    = OUT_WIDTH_DEF,
  parameter coef_t COEF_INIT    = '0
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  cell_ctrl_t                        ctrl_i,
  input  logic signed [SAMPLE_WIDTH-1:0]    x_i,
  input  logic signed [OUT_WIDTH-1:0]       y_i,
  output logic signed [SAMPLE_WIDTH-1:0]    x_o,
  output logic signed [OUT_WIDTH-1:0]       y_o,
  output logic signed [COEF_W+OUT_WIDTH-1:0] prod_o
);

  localparam int PROD_W = COEF_W + OUT_WIDTH;

  logic signed [SAMPLE_WIDTH-1:0] x_q, x_d;
  logic signed [OUT_WIDTH-1:0]    y_q, y_d;
  coef_t                          coef_q, coef_d;

  always_comb begin
    x_d    = ctrl_i.shift ? x_i : x_q;
    y_d    = ctrl_i.shift ? y_i : y_q;
    coef_d = ctrl_i.coef_we ? ctrl_i.coef_wdata : coef_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q    <= '0;
      y_q    <= '0;
      coef_q <= COEF_INIT;
    end else begin
      x_q    <= x_d;
      y_q    <= y_d;
      coef_q <= coef_d;
    end
  end

  assign x_o    = x_q;
  assign y_o    = y_q;
  assign prod_o = PROD_W'(coef_q) * PROD_W'(y_q);

endmodule

### hdl/soiir_sum.sv
// adder tree, truncating shift, feedforward add and output saturation
// combines the products of the tap cells; uses soiir_pkg
module soiir_sum
  import soiir_pkg::*;
#(
  parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
  parameter int OUT_WIDTH      = OUT_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic signed [COEF_W+OUT_WIDTH-1:0] prod_i [NTAPS],
  input  logic signed [SAMPLE_WIDTH-1:0]     x_cur_i,
  input  logic signed [SAMPLE_WIDTH-1:0]     x_hist_i [NTAPS],
  output logic signed [OUT_WIDTH-1:0]        y_o,
  output logic                               clip_o
);

  localparam int PROD_W = COEF_W + OUT_WIDTH;
  localparam int ACC_W  = PROD_W + 3;
  localparam int FF_W   = SAMPLE_WIDTH + 3;
  localparam int SUM_W  = ((ACC_W > FF_W) ? ACC_W : FF_W) + 1;

  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_sh;
  logic signed [SUM_W-1:0] y_full;
  logic                    ovf;

  always_comb begin
    acc = '0;
    for (int k = 0; k < NTAPS; k++) begin
      acc = acc + ACC_W'(prod_i[k]);
    end
  end

  // arithmetic shift floors, matching truncation of the exact sum
  assign acc_sh = acc >>> COEF_FRAC_BITS;

  // x[n-6] + x[n-4] - x[n-2] - x[n]
  assign y_full = SUM_W'(acc_sh) + SUM_W'(x_hist_i[5]) + SUM_W'(x_hist_i[3])
                - SUM_W'(x_hist_i[1]) - SUM_W'(x_cur_i);

  // overflow when the bits above the output sign differ from the sign
  assign ovf = (y_full[SUM_W-1:OUT_WIDTH-1] != {(SUM_W-OUT_WIDTH+1){y_full[SUM_W-1]}});

  always_comb begin
    if (ovf) begin
      y_o = y_full[SUM_W-1] ? {1'b1, {(OUT_WIDTH-1){1'b0}}}
                            : {1'b0, {(OUT_WIDTH-1){1'b1}}};
    end else begin
      y_o = y_full[OUT_WIDTH-1:0];
    end
  end

  assign clip_o = ovf;

endmodule

### hdl/sixth_order_iir_filter_top.sv
// sixth-order direct-form-i iir filter, top level
// takes one sample per cycle and returns one sample per cycle, in the cycle after acceptance,
// from an output register that takes the next sample in the same cycle its waiting result
// leaves, so the input stalls only while the result side holds off. the rate is
// set by the feedback loop: six tap-cell multipliers and one adder tree produce y[n] from
// the registered output history combinationally. coefficients reset to their default
// q3.12 values and the history clears at reset, with no warm-up. config writes are always
// taken; indexes above five are ignored. uses soiir_pkg, soiir_cell and soiir_sum
module sixth_order_iir_filter_top
  import soiir_pkg::*;
#(
  parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
  parameter int OUT_WIDTH      = OUT_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   s_axis_tdata,   // sample_in
  // output stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [((OUT_WIDTH+7)/8)*8-1:0]      m_axis_tdata,   // sample_out
  output logic                                m_axis_tuser,   // clipped
  // coefficient writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]                cfg_index_i,
  input  logic [COEF_W-1:0]                   cfg_data_i
);

  localparam int PROD_W   = COEF_W + OUT_WIDTH;
  localparam int OUT_TD_W = ((OUT_WIDTH + 7) / 8) * 8;

  logic                           in_beat;
  logic                           cfg_beat;
  logic signed [SAMPLE_WIDTH-1:0] x_cur;
  logic signed [OUT_WIDTH-1:0]    y_new;
  logic                           clip_new;

  logic signed [SAMPLE_WIDTH-1:0] x_hist [NTAPS];
  logic signed [OUT_WIDTH-1:0]    y_hist [NTAPS];
  logic signed [PROD_W-1:0]       prod   [NTAPS];
  cell_ctrl_t                     ctrl   [NTAPS];

  logic                           out_valid_q, out_valid_d;
  logic signed [OUT_WIDTH-1:0]    out_y_q, out_y_d;
  logic                           out_clip_q, out_clip_d;

  assign cfg_ready_o   = 1'b1;
  assign cfg_beat      = cfg_valid_i & cfg_ready_o;
  assign s_axis_tready = ~out_valid_q | m_axis_tready;
  assign in_beat       = s_axis_tvalid & s_axis_tready;
  assign x_cur         = s_axis_tdata[SAMPLE_WIDTH-1:0];

  for (genvar k = 0; k < NTAPS; k++) begin : g_cell
    assign ctrl[k] = '{
      shift:      in_beat,
      coef_we:    cfg_beat & (cfg_index_i == CFG_IDX_W'(k)),
      coef_wdata: cfg_data_i
    };

    if (k == 0) begin : g_head
      soiir_cell #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .OUT_WIDTH    (OUT_WIDTH),
        .COEF_INIT    (COEF_RESET[k])
      ) u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctrl_i (ctrl[k]),
        .x_i    (x_cur),
        .y_i    (y_new),
        .x_o    (x_hist[k]),
        .y_o    (y_hist[k]),
        .prod_o (prod[k])
      );
    end else begin : g_body
      soiir_cell #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .OUT_WIDTH    (OUT_WIDTH),
        .COEF_INIT    (COEF_RESET[k])
      ) u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctrl_i (ctrl[k]),
        .x_i    (x_hist[k-1]),
        .y_i    (y_hist[k-1]),
        .x_o    (x_hist[k]),
        .y_o    (y_hist[k]),
        .prod_o (prod[k])
      );
    end
  end

  soiir_sum #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .OUT_WIDTH      (OUT_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_sum (
    .prod_i   (prod),
    .x_cur_i  (x_cur),
    .x_hist_i (x_hist),
    .y_o      (y_new),
    .clip_o   (clip_new)
  );

  // output register, reloaded on every accepted beat
  always_comb begin
    out_valid_d = out_valid_q;
    out_y_d     = out_y_q;
    out_clip_d  = out_clip_q;
    if (in_beat) begin
      out_valid_d = 1'b1;
      out_y_d     = y_new;
      out_clip_d  = clip_new;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_y_q    <= out_y_d;
    out_clip_q <= out_clip_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TD_W'($unsigned(out_y_q));
  assign m_axis_tuser  = out_clip_q;

endmodule

### verif/soiir_response_check.sv
// response checker for the sixth-order iir filter: watches the sample, result and
// coefficient channels, predicts each filtered sample and compares it on arrival
// depends on soiir_pkg
module soiir_response_check
  import soiir_pkg::*;
(
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    s_axis_tvalid,
  input  logic                                    s_axis_tready,
  input  logic [((SAMPLE_WIDTH_DEF+7)/8)*8-1:0]   s_axis_tdata,   // sample_in
  input  logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  input  logic [((OUT_WIDTH_DEF+7)/8)*8-1:0]      m_axis_tdata,   // sample_out
  input  logic                                    m_axis_tuser,   // clipped
  input  logic                                    cfg_valid_i,
  input  logic                                    cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]                    cfg_index_i,
  input  logic [COEF_W-1:0]                       cfg_data_i,
  output int                                      fail_count_o,
  output int                                      pending_o,
  output int                                      results_o,
  output int                                      clipped_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SW   = SAMPLE_WIDTH_DEF;
  localparam int OW   = OUT_WIDTH_DEF;
  localparam int FRAC = COEF_FRAC_BITS_DEF;
  localparam longint Y_MAX = (longint'(1) <<< (OW - 1)) - 1;
  localparam longint Y_MIN = -Y_MAX - 1;

  typedef struct packed {
    logic signed [OW-1:0] sample;
    logic                 clipped;
  } filtered_t;

  coef_t                coef_q [NTAPS];
  logic signed [SW-1:0] x_hist [NTAPS];   // x[n-1] .. x[n-6]
  logic signed [OW-1:0] y_hist [NTAPS];   // y[n-1] .. y[n-6]
  filtered_t            filtered_q [$];

  function automatic filtered_t next_filtered(input logic signed [SW-1:0] x);
    longint    acc;
    longint    y;
    filtered_t r;
    acc = 0;
    for (int k = 0; k < NTAPS; k++) begin
      acc += longint'(coef_q[k]) * longint'(y_hist[k]);
    end
    // feedback sum floors on the shift, feedforward added exactly afterwards
    y = (acc >>> FRAC) + longint'(x_hist[5]) + longint'(x_hist[3])
        - longint'(x_hist[1]) - longint'(x);
    r.clipped = 1'b0;
    if (y > Y_MAX) begin
      y = Y_MAX;
      r.clipped = 1'b1;
    end else if (y < Y_MIN) begin
      y = Y_MIN;
      r.clipped = 1'b1;
    end
    r.sample = y[OW-1:0];
    for (int k = NTAPS - 1; k > 0; k--) begin
      x_hist[k] = x_hist[k-1];
      y_hist[k] = y_hist[k-1];
    end
    x_hist[0] = x;
    y_hist[0] = r.sample;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    filtered_t want;
    filtered_t got;
    if (!rst_ni) begin
      for (int k = 0; k < NTAPS; k++) begin
        coef_q[k] = COEF_RESET[k];
        x_hist[k] = '0;
        y_hist[k] = '0;
      end
      filtered_q.delete();
      fail_count_o = 0;
      results_o    = 0;
      clipped_o    = 0;
    end else begin
      // compare first: a result never belongs to a sample taken at the same edge
      if (m_axis_tvalid && m_axis_tready) begin
        got.sample  = m_axis_tdata[OW-1:0];
        got.clipped = m_axis_tuser;
        results_o++;
        if (got.clipped) clipped_o++;
        if (filtered_q.size() == 0) begin
          fail_count_o++;
          $display("%0t ns: result beat with nothing expected, got sample_out %0d clipped %0b",
                   $time, got.sample, got.clipped);
        end else begin
          want = filtered_q.pop_front();
          if (got.sample !== want.sample) begin
            fail_count_o++;
            $display("%0t ns: sample_out mismatch, expected %0d, got %0d",
                     $time, want.sample, got.sample);
          end
          if (got.clipped !== want.clipped) begin
            fail_count_o++;
            $display("%0t ns: clipped mismatch, expected %0b, got %0b",
                     $time, want.clipped, got.clipped);
          end
        end
      end
      // a sample taken at this edge still sees the old coefficients
      if (s_axis_tvalid && s_axis_tready) begin
        filtered_q.push_back(next_filtered(s_axis_tdata[SW-1:0]));
      end
      // indexes past the last tap are dropped
      if (cfg_valid_i && cfg_ready_o && cfg_index_i < NTAPS) begin
        coef_q[cfg_index_i] = cfg_data_i;
      end
    end
    pending_o = filtered_q.size();
  end

endmodule

### verif/tb.sv
// testbench top for sixth_order_iir_filter_top: drives samples and coefficient writes,
// stalls both streams at random and gives the verdict
// depends on soiir_pkg, the filter rtl and soiir_response_check
module tb
  import soiir_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SW          = SAMPLE_WIDTH_DEF;
  localparam int OW          = OUT_WIDTH_DEF;
  localparam int TD_IN       = ((SW + 7) / 8) * 8;
  localparam int TD_OUT      = ((OW + 7) / 8) * 8;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 8;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 90;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_Y1, REG_COEF_Y2, REG_COEF_Y3, REG_COEF_Y4, REG_COEF_Y5, REG_COEF_Y6,
    REG_SPARE6, REG_SPARE7
  } cfg_reg_e;

  // impulses of both signs, ringing zeros, unit values, full-scale steps and alternating bit patterns
  localparam logic [SW-1:0] DIRECTED [20] = '{
    16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
    16'h8000, 16'h0000, 16'h0000, 16'h0001, 16'hFFFF, 16'h5555, 16'hAAAA,
    16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h0000, 16'h0000
  };

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [TD_IN-1:0]     s_axis_tdata  = '0;   // sample_in
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [TD_OUT-1:0]    m_axis_tdata;         // sample_out
  logic                 m_axis_tuser;         // clipped
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i   = '0;
  logic [COEF_W-1:0]    cfg_data_i    = '0;

  int fail_count;
  int pending;
  int results;
  int clipped;
  int samples_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  sixth_order_iir_filter_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  soiir_response_check i_response_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .results_o     (results),
    .clipped_o     (clipped)
  );

  // result side: random stalls, plus a long hold-off whenever one is requested
  always @(posedge clk_i) begin
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic logic [SW-1:0] rand_sample();
    logic [SW-1:0] v;
    v = SW'($urandom);
    case ($urandom_range(9))
      0, 1, 2, 3, 4: ;
      5, 6:    v = {{(SW-7){v[6]}}, v[6:0]};         // small signed
      7:       v = {v[0], {(SW-1){~v[0]}}};          // full-scale either way
      8:       v = {{(SW-1){v[1]}}, v[0]};           // around zero
      default: v[SW-1 -: 2] = {v[SW-1], ~v[SW-1]};   // large magnitude
    endcase
    return v;
  endfunction

  task automatic push_sample(input logic [SW-1:0] smp);
    s_axis_tdata  <= smp;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    samples_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic cfg_beat(input cfg_reg_e idx, input coef_t val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  // unused indexes go first and must leave the taps alone
  task automatic program_coefs(input coef_t c [NTAPS]);
    cfg_beat(REG_SPARE6, coef_t'($urandom));
    cfg_beat(REG_SPARE7, coef_t'($urandom));
    for (int k = 0; k < NTAPS; k++) cfg_beat(cfg_reg_e'(k), c[k]);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    coef_t cset [NTAPS];
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset coefficients, back-to-back
    foreach (DIRECTED[i]) push_sample(DIRECTED[i]);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      for (int k = 0; k < NTAPS; k++) begin
        case (p)
          0: cset[k] = '0;                                        // fir path only
          1: cset[k] = 16'sh7FFF;
          2: cset[k] = 16'sh8000;
          3: cset[k] = (k == 0) ? 16'sd4096 : 16'sd0;             // integrator, drifts to clip
          4: cset[k] = coef_t'($urandom);
          5: cset[k] = coef_t'($urandom_range(16383) - 8192);
          6: cset[k] = COEF_RESET[k];
          default: cset[k] = (k % 2 == 0) ? 16'sh7FFF : 16'sh8000;
        endcase
      end
      program_coefs(cset);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      // back-pressure: results held off while samples keep coming
      if (p == 4) begin
        hold_reqs++;
        repeat (40) push_sample(rand_sample());
      end
      repeat (PHASE_ITEMS) push_sample(rand_sample());
      drain();
    end

    $display("run covered %0d samples under %0d coefficient sets and four idling mixes",
             samples_sent, PHASES + 1);
    $display("%0d results checked, %0d of them saturated", results, clipped);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2_400_000;
    $display("timeout with %0d results outstanding", pending);
    $display("Regression FAIL");
    $finish;
  end

endmodule

### filelist.f
hdl/soiir_pkg.sv
hdl/soiir_cell.sv
hdl/soiir_sum.sv
hdl/sixth_order_iir_filter_top.sv
verif/soiir_response_check.sv
verif/tb.sv
